>>> rtl/assert_macros.svh
// Assertion helpers for the RTL. The first form checks only outside reset,
// the second also checks while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

`define ASSERT_CLK_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define ASSERT_CLK(lbl, clk, rst, prop)

`define ASSERT_CLK_ALWAYS(lbl, clk, prop)

`endif

`endif

>>> rtl/ebalu_pkg.sv
`timescale 1ns / 1ps

package ebalu_pkg;

  typedef enum logic [4:0] {
    FN_ADD      = 5'd0,
    FN_ADC      = 5'd1,
    FN_SUB      = 5'd2,
    FN_SBC      = 5'd3,
    FN_AND      = 5'd4,
    FN_XOR      = 5'd5,
    FN_OR       = 5'd6,
    FN_CP       = 5'd7,
    FN_INC      = 5'd8,
    FN_DEC      = 5'd9,
    FN_RLCA     = 5'd10,
    FN_RRCA     = 5'd11,
    FN_RLA      = 5'd12,
    FN_RRA      = 5'd13,
    FN_RLC      = 5'd14,
    FN_RRC      = 5'd15,
    FN_RL       = 5'd16,
    FN_RR       = 5'd17,
    FN_SLA      = 5'd18,
    FN_SRA      = 5'd19,
    FN_SWAP     = 5'd20,
    FN_SRL      = 5'd21,
    FN_BIT      = 5'd22,
    FN_RES      = 5'd23,
    FN_SET      = 5'd24,
    FN_DAA      = 5'd25,
    FN_CPL      = 5'd26,
    FN_SCF      = 5'd27,
    FN_CCF      = 5'd28,
    FN_ADD16    = 5'd29,
    FN_ADDSPOFF = 5'd30
  } func_t;

  // flag bit positions
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  localparam logic [7:0] DAA_LO_ADJ   = 8'h06;
  localparam logic [7:0] DAA_HI_ADJ   = 8'h60;
  localparam logic [7:0] DAA_HI_LIMIT = 8'h99;

  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 32;

endpackage

>>> rtl/eight_bit_alu_with_flags_unit.sv
`timescale 1ns / 1ps
// Channel   Dir  Width  Contents
// s_axis    in   64     func, opa, opb, bit_sel, flags_in, wide_a, wide_b
// m_axis    out  32     res_byte, res_word, flags_out, write_en
//
// One operation per cycle sustained while m_axis_tready stays high; each result
// passes the input register, then ALU logic into the result register.
// rst clears both stage valid bits; payload registers are not reset.
// A stalled result holds in the result register while one more operation
// waits in the input register; s_axis_tready drops only when both are full.
`include "assert_macros.svh"

module eight_bit_alu_with_flags_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [4:0] func, [12:5] opa, [20:13] opb, [23:21] bit_sel, [27:24] flags_in,
  // [43:28] wide_a, [59:44] wide_b, [63:60] zero
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] res_byte, [23:8] res_word, [27:24] flags_out, [28] write_en,
  // [31:29] zero
  output logic [31:0] m_axis_tdata
);

  // input register
  logic                 in_valid;
  ebalu_pkg::func_t     in_func;
  logic [7:0]           in_opa;
  logic [7:0]           in_opb;
  logic [2:0]           in_bit_sel;
  logic [3:0]           in_flags;
  logic [15:0]          in_wide_a;
  logic [15:0]          in_wide_b;

  // result register
  logic                 out_valid;
  logic [7:0]           out_res_byte;
  logic [15:0]          out_res_word;
  logic [3:0]           out_flags;
  logic                 out_write_en;

  logic                 advance;

  // ALU outputs
  logic [7:0]           rb;
  logic [15:0]          rw;
  logic [3:0]           fo;
  logic                 we;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_write_en, out_flags, out_res_word, out_res_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_func    <= ebalu_pkg::func_t'(s_axis_tdata[4:0]);
      in_opa     <= s_axis_tdata[12:5];
      in_opb     <= s_axis_tdata[20:13];
      in_bit_sel <= s_axis_tdata[23:21];
      in_flags   <= s_axis_tdata[27:24];
      in_wide_a  <= s_axis_tdata[43:28];
      in_wide_b  <= s_axis_tdata[59:44];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_res_byte <= rb;
      out_res_word <= rw;
      out_flags    <= fo;
      out_write_en <= we;
    end
  end

  always_comb begin
    logic       cin;
    logic       t;
    logic [8:0] sum9;
    logic [4:0] sum5;
    logic [8:0] dif9;
    logic [4:0] dif5;
    logic [7:0] mask;
    logic [7:0] adj;
    logic       dc;
    logic [16:0] sum17;
    logic [12:0] sum13;
    logic [15:0] offs;

    cin   = in_flags[ebalu_pkg::FLAG_C];
    t     = ((in_func == ebalu_pkg::FN_ADC) || (in_func == ebalu_pkg::FN_SBC)) && cin;
    sum9  = {1'b0, in_opa} + {1'b0, in_opb} + {8'd0, t};
    sum5  = {1'b0, in_opa[3:0]} + {1'b0, in_opb[3:0]} + {4'd0, t};
    dif9  = {1'b0, in_opa} - {1'b0, in_opb} - {8'd0, t};
    dif5  = {1'b0, in_opa[3:0]} - {1'b0, in_opb[3:0]} - {4'd0, t};
    mask  = 8'd1 << in_bit_sel;
    sum17 = {1'b0, in_wide_a} + {1'b0, in_wide_b};
    sum13 = {1'b0, in_wide_a[11:0]} + {1'b0, in_wide_b[11:0]};
    offs  = {{8{in_opb[7]}}, in_opb};
    adj   = 8'd0;
    dc    = cin;

    rb = 8'd0;
    rw = 16'd0;
    fo = in_flags;
    we = 1'b1;

    case (in_func)
      ebalu_pkg::FN_ADD, ebalu_pkg::FN_ADC: begin
        rb = sum9[7:0];
        fo = {rb == 8'd0, 1'b0, sum5[4], sum9[8]};
      end
      ebalu_pkg::FN_SUB, ebalu_pkg::FN_SBC, ebalu_pkg::FN_CP: begin
        rb = dif9[7:0];
        fo = {rb == 8'd0, 1'b1, dif5[4], dif9[8]};
        if (in_func == ebalu_pkg::FN_CP) begin
          rb = in_opa;
          we = 1'b0;
        end
      end
      ebalu_pkg::FN_AND: begin
        rb = in_opa & in_opb;
        fo = {rb == 8'd0, 1'b0, 1'b1, 1'b0};
      end
      ebalu_pkg::FN_XOR: begin
        rb = in_opa ^ in_opb;
        fo = {rb == 8'd0, 3'b000};
      end
      ebalu_pkg::FN_OR: begin
        rb = in_opa | in_opb;
        fo = {rb == 8'd0, 3'b000};
      end
      ebalu_pkg::FN_INC: begin
        rb = in_opa + 8'd1;
        fo = {rb == 8'd0, 1'b0, in_opa[3:0] == 4'hf, cin};
      end
      ebalu_pkg::FN_DEC: begin
        rb = in_opa - 8'd1;
        fo = {rb == 8'd0, 1'b1, in_opa[3:0] == 4'h0, cin};
      end
      ebalu_pkg::FN_RLCA: begin
        rb = {in_opa[6:0], in_opa[7]};
        fo = {3'b000, in_opa[7]};
      end
      ebalu_pkg::FN_RRCA: begin
        rb = {in_opa[0], in_opa[7:1]};
        fo = {3'b000, in_opa[0]};
      end
      ebalu_pkg::FN_RLA: begin
        rb = {in_opa[6:0], cin};
        fo = {3'b000, in_opa[7]};
      end
      ebalu_pkg::FN_RRA: begin
        rb = {cin, in_opa[7:1]};
        fo = {3'b000, in_opa[0]};
      end
      ebalu_pkg::FN_RLC: begin
        rb = {in_opa[6:0], in_opa[7]};
        fo = {rb == 8'd0, 2'b00, in_opa[7]};
      end
      ebalu_pkg::FN_RRC: begin
        rb = {in_opa[0], in_opa[7:1]};
        fo = {rb == 8'd0, 2'b00, in_opa[0]};
      end
      ebalu_pkg::FN_RL: begin
        rb = {in_opa[6:0], cin};
        fo = {rb == 8'd0, 2'b00, in_opa[7]};
      end
      ebalu_pkg::FN_RR: begin
        rb = {cin, in_opa[7:1]};
        fo = {rb == 8'd0, 2'b00, in_opa[0]};
      end
      ebalu_pkg::FN_SLA: begin
        rb = {in_opa[6:0], 1'b0};
        fo = {rb == 8'd0, 2'b00, in_opa[7]};
      end
      ebalu_pkg::FN_SRA: begin
        rb = {in_opa[7], in_opa[7:1]};
        fo = {rb == 8'd0, 2'b00, in_opa[0]};
      end
      ebalu_pkg::FN_SWAP: begin
        rb = {in_opa[3:0], in_opa[7:4]};
        fo = {rb == 8'd0, 3'b000};
      end
      ebalu_pkg::FN_SRL: begin
        rb = {1'b0, in_opa[7:1]};
        fo = {rb == 8'd0, 2'b00, in_opa[0]};
      end
      ebalu_pkg::FN_BIT: begin
        rb = in_opa;
        we = 1'b0;
        fo = {(in_opa & mask) == 8'd0, 1'b0, 1'b1, cin};
      end
      ebalu_pkg::FN_RES: rb = in_opa & ~mask;
      ebalu_pkg::FN_SET: rb = in_opa | mask;
      ebalu_pkg::FN_DAA: begin
        if (!in_flags[ebalu_pkg::FLAG_N]) begin
          if (in_flags[ebalu_pkg::FLAG_H] || (in_opa[3:0] > 4'd9)) begin
            adj = adj | ebalu_pkg::DAA_LO_ADJ;
          end
          if (cin || (in_opa > ebalu_pkg::DAA_HI_LIMIT)) begin
            adj = adj | ebalu_pkg::DAA_HI_ADJ;
            dc  = 1'b1;
          end
          rb = in_opa + adj;
        end else begin
          if (in_flags[ebalu_pkg::FLAG_H]) begin
            adj = adj | ebalu_pkg::DAA_LO_ADJ;
          end
          if (cin) begin
            adj = adj | ebalu_pkg::DAA_HI_ADJ;
          end
          rb = in_opa - adj;
        end
        fo = {rb == 8'd0, in_flags[ebalu_pkg::FLAG_N], 1'b0, dc};
      end
      ebalu_pkg::FN_CPL: begin
        rb = ~in_opa;
        fo = {in_flags[ebalu_pkg::FLAG_Z], 1'b1, 1'b1, cin};
      end
      ebalu_pkg::FN_SCF: begin
        rb = in_opa;
        fo = {in_flags[ebalu_pkg::FLAG_Z], 2'b00, 1'b1};
      end
      ebalu_pkg::FN_CCF: begin
        rb = in_opa;
        fo = {in_flags[ebalu_pkg::FLAG_Z], 2'b00, ~cin};
      end
      ebalu_pkg::FN_ADD16: begin
        rw = sum17[15:0];
        fo = {in_flags[ebalu_pkg::FLAG_Z], 1'b0, sum13[12], sum17[16]};
      end
      ebalu_pkg::FN_ADDSPOFF: begin
        // flags come from the unsigned low nibble and low byte sums
        rw = in_wide_a + offs;
        sum9 = {1'b0, in_wide_a[7:0]} + {1'b0, in_opb};
        sum5 = {1'b0, in_wide_a[3:0]} + {1'b0, in_opb[3:0]};
        fo = {2'b00, sum5[4], sum9[8]};
      end
      default: begin
        // unassigned code: pass the operand, keep flags, no write back
        rb = in_opa;
        we = 1'b0;
      end
    endcase
  end

  `ASSERT_CLK_ALWAYS(a_reset_empties, clk, rst |=> (!in_valid && !out_valid))
  `ASSERT_CLK(a_accept_loads, clk, rst, (s_axis_tvalid && s_axis_tready) |=> in_valid)
  `ASSERT_CLK(a_hold_input, clk, rst, (in_valid && !advance) |=> (in_valid && $stable(in_opa) && $stable(in_func)))
  `ASSERT_CLK(a_no_write_cmp, clk, rst, (in_valid && ((in_func == ebalu_pkg::FN_CP) || (in_func == ebalu_pkg::FN_BIT))) |-> !we)
  `ASSERT_CLK(a_word_ops_byte_zero, clk, rst, (in_valid && ((in_func == ebalu_pkg::FN_ADD16) || (in_func == ebalu_pkg::FN_ADDSPOFF))) |-> (rb == 8'd0))

endmodule
